>>> src/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and helpers for the ray/sphere intersect unit
// Fixed-point value type, register codes, stage tag layouts, saturation.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NORM_BITS     = 16;
	localparam int SAT_W         = 72;

	localparam logic [30:0] RADIUS_RST = 31'd65536;
	localparam logic [30:0] DLIMIT_RST = 31'd655360000;

	typedef enum logic [2:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_CENTER_Z   = 3'd2,
		REG_RADIUS     = 3'd3,
		REG_DISC_LIMIT = 3'd4
	} cfg_reg_t;

	typedef logic signed [31:0] fx_t;

	// tag riding through the discriminant square root
	typedef struct packed {
		logic        hit;
		logic        qlow;
		fx_t         h;
		fx_t         a;
		fx_t [2:0]   o;
		fx_t [2:0]   d;
		fx_t         tmin;
		fx_t         tmax;
	} sq1_tag_t;

	// tag riding through the root dividers
	typedef struct packed {
		logic [1:0]  neg;
		logic [1:0]  ovf;
		logic        hit;
		logic        qlow;
		fx_t [2:0]   o;
		fx_t [2:0]   d;
		fx_t         tmin;
		fx_t         tmax;
	} dv1_tag_t;

	// tag riding through the length square root
	typedef struct packed {
		fx_t [2:0]   v;
		fx_t [2:0]   p;
		fx_t         t1;
		logic        hit;
		logic        occ;
	} sq2_tag_t;

	// tag riding through the normal dividers
	typedef struct packed {
		logic [2:0]  neg;
		logic        lenz;
		fx_t [2:0]   p;
		fx_t         t1;
		logic        hit;
		logic        occ;
	} dv2_tag_t;

	localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2147483647);
	localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

	function automatic fx_t sat32(input logic signed [SAT_W-1:0] v);
		fx_t r;
		if (v > SAT_HI) begin
			r = fx_t'(SAT_HI[31:0]);
		end else if (v < SAT_LO) begin
			r = fx_t'(SAT_LO[31:0]);
		end else begin
			r = fx_t'(v[31:0]);
		end
		return r;
	endfunction

	function automatic fx_t sub_sat(input fx_t a, input fx_t b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return sat32(SAT_W'(d));
	endfunction

endpackage

>>> src/rsi_isqrt.sv
// ----------------------------------------------------------------------------
// rsi_isqrt: pipelined integer square root
// One root bit per stage, IW/2 stages, floor result; a tag travels alongside.
// ----------------------------------------------------------------------------
module rsi_isqrt #(
	parameter int IW = 64,
	parameter int TW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [IW-1:0]     in_rad,
	input  logic [TW-1:0]     in_tag,
	output logic              out_vld,
	output logic [IW/2-1:0]   out_root,
	output logic [TW-1:0]     out_tag
);
	localparam int RW = IW / 2;

	logic              vld_q  [RW];
	logic [RW+1:0]     rem_q  [RW];
	logic [RW-1:0]     root_q [RW];
	logic [IW-1:0]     x_q    [RW];
	logic [TW-1:0]     tag_q  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_st
		logic          vld_i;
		logic [RW+1:0] rem_i;
		logic [RW-1:0] root_i;
		logic [IW-1:0] x_i;
		logic [TW-1:0] tag_i;
		logic [RW+3:0] cat;
		logic [RW+3:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_i  = in_vld;
			assign rem_i  = '0;
			assign root_i = '0;
			assign x_i    = in_rad;
			assign tag_i  = in_tag;
		end else begin : g_next
			assign vld_i  = vld_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign x_i    = x_q[k-1];
			assign tag_i  = tag_q[k-1];
		end

		assign cat   = {rem_i, x_i[IW-1:IW-2]};
		assign trial = (RW+4)'({root_i, 2'b01});
		assign ge    = cat >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? (RW+2)'(cat - trial) : (RW+2)'(cat);
				root_q[k] <= {root_i[RW-2:0], ge};
				x_q[k]    <= {x_i[IW-3:0], 2'b00};
				tag_q[k]  <= tag_i;
			end
		end
	end

	assign out_vld  = vld_q[RW-1];
	assign out_root = root_q[RW-1];
	assign out_tag  = tag_q[RW-1];

endmodule

>>> src/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div: pipelined restoring divider, several lanes over one divisor
// One quotient bit per stage; partial remainder starts below the divisor.
// ----------------------------------------------------------------------------
module rsi_div #(
	parameter int DW    = 32,
	parameter int QW    = 32,
	parameter int LANES = 1,
	parameter int TW    = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [DW-1:0]              in_den,
	input  logic [LANES-1:0][DW-1:0]   in_rem,
	input  logic [LANES-1:0][QW-1:0]   in_num,
	input  logic [TW-1:0]              in_tag,
	output logic                       out_vld,
	output logic [LANES-1:0][QW-1:0]   out_quo,
	output logic [LANES-1:0]           out_rnz,
	output logic [TW-1:0]              out_tag
);
	logic                      vld_q [QW];
	logic [DW-1:0]             den_q [QW];
	logic [LANES-1:0][DW-1:0]  rem_q [QW];
	logic [LANES-1:0][QW-1:0]  nq_q  [QW];
	logic [TW-1:0]             tag_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic                      vld_i;
		logic [DW-1:0]             den_i;
		logic [LANES-1:0][DW-1:0]  rem_i;
		logic [LANES-1:0][QW-1:0]  nq_i;
		logic [TW-1:0]             tag_i;
		logic [LANES-1:0][DW-1:0]  rem_n;
		logic [LANES-1:0][QW-1:0]  nq_n;

		if (k == 0) begin : g_first
			assign vld_i = in_vld;
			assign den_i = in_den;
			assign rem_i = in_rem;
			assign nq_i  = in_num;
			assign tag_i = in_tag;
		end else begin : g_next
			assign vld_i = vld_q[k-1];
			assign den_i = den_q[k-1];
			assign rem_i = rem_q[k-1];
			assign nq_i  = nq_q[k-1];
			assign tag_i = tag_q[k-1];
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				logic [DW:0] cat;
				logic        ge;
				cat = {rem_i[l], nq_i[l][QW-1]};
				ge  = cat >= {1'b0, den_i};
				rem_n[l] = ge ? DW'(cat - {1'b0, den_i}) : DW'(cat);
				// numerator bits shift out the top, quotient bits shift in below
				nq_n[l]  = {nq_i[l][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k] <= den_i;
				rem_q[k] <= rem_n;
				nq_q[k]  <= nq_n;
				tag_q[k] <= tag_i;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_rnz[l] = rem_q[QW-1][l] != '0;
		end
	end

	assign out_vld = vld_q[QW-1];
	assign out_quo = nq_q[QW-1];
	assign out_tag = tag_q[QW-1];

endmodule

>>> src/rsi_skid.sv
// ----------------------------------------------------------------------------
// rsi_skid: output register with one spare entry
// Ready toward the pipeline is registered; it drops only when the spare fills.
// ----------------------------------------------------------------------------
module rsi_skid #(
	parameter int W = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [W-1:0]  in_data,
	output logic          in_rdy,
	output logic          out_vld,
	input  logic          out_rdy,
	output logic [W-1:0]  out_data
);
	logic          out_vld_q;
	logic          spare_vld_q;
	logic [W-1:0]  out_q;
	logic [W-1:0]  spare_q;

	assign in_rdy   = !spare_vld_q;
	assign out_vld  = out_vld_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			spare_vld_q <= 1'b0;
		end else if (!out_vld_q || out_rdy) begin
			if (spare_vld_q) begin
				out_vld_q   <= 1'b1;
				spare_vld_q <= 1'b0;
			end else begin
				out_vld_q <= in_vld;
			end
		end else if (in_vld && !spare_vld_q) begin
			spare_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_rdy) begin
			out_q <= spare_vld_q ? spare_q : in_data;
		end else if (!spare_vld_q) begin
			spare_q <= in_data;
		end
	end

endmodule

>>> src/ray_sphere_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit: ray against configured sphere, one ray per cycle while not stalled
// Throughput: one word per cycle while not stalled; the two 32-stage square roots and the
// 32-stage root divider set the depth, each a bit per stage.
// Reset: arst_n clears valid state and loads center 0, radius 1.0, limit 10000.
// Backpressure stalls the whole pipeline; one spare entry sits at the output.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_unit #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [31:0]   cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
	input  logic [255:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// hit, hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z, occluded
	output logic [183:0]  m_tdata
);
	import rsi_pkg::*;

	localparam int PW    = 64 - FRAC_BITS;
	localparam int SUMW  = PW + 2;
	localparam int NMW   = 33 + FRAC_BITS;
	localparam int OUT_W = 184;

	// ---------------- configuration ----------------
	fx_t          cx_q, cy_q, cz_q;
	logic [30:0]  rad_q, dlim_q;
	fx_t [2:0]    ctr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			cz_q   <= '0;
			rad_q  <= RADIUS_RST;
			dlim_q <= DLIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_CENTER_X:   cx_q   <= cfg_wdata;
				REG_CENTER_Y:   cy_q   <= cfg_wdata;
				REG_CENTER_Z:   cz_q   <= cfg_wdata;
				REG_RADIUS:     rad_q  <= cfg_wdata[30:0];
				REG_DISC_LIMIT: dlim_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	assign ctr = {cz_q, cy_q, cx_q};

	logic en;
	assign s_tready = en;

	// ---------------- front stages ----------------
	fx_t [2:0]  o_in, d_in;
	assign o_in = s_tdata[95:0];
	assign d_in = s_tdata[191:96];

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	fx_t [2:0]   o_s1, d_s1, oc_s1;
	fx_t         tmin_s1, tmax_s1;

	logic signed [PW-1:0] dd_s2 [3];
	logic signed [PW-1:0] od_s2 [3];
	logic signed [PW-1:0] oo_s2 [3];
	logic [PW-1:0]        rr_s2;
	fx_t [2:0]            o_s2, d_s2;
	fx_t                  tmin_s2, tmax_s2;

	fx_t        a_s3, h_s3, cc_s3;
	fx_t [2:0]  o_s3, d_s3;
	fx_t        tmin_s3, tmax_s3;

	logic signed [63:0] hh_s4, acc_s4;
	fx_t        a_s4, h_s4;
	fx_t [2:0]  o_s4, d_s4;
	fx_t        tmin_s4, tmax_s4;

	logic [63:0] q_s5;
	sq1_tag_t    tag_s5;

	logic signed [63:0]    m_dd [3];
	logic signed [63:0]    m_od [3];
	logic signed [63:0]    m_oo [3];
	logic [63:0]           m_rr;
	logic signed [SUMW-1:0] sa3, sh3, sc3;
	logic signed [64:0]    qd5;
	logic [63:0]           lim5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_dd[i] = 64'(d_s1[i]) * 64'(d_s1[i]);
			m_od[i] = 64'(oc_s1[i]) * 64'(d_s1[i]);
			m_oo[i] = 64'(oc_s1[i]) * 64'(oc_s1[i]);
		end
		m_rr = 64'(rad_q) * 64'(rad_q);
		sa3 = SUMW'(dd_s2[0]) + SUMW'(dd_s2[1]) + SUMW'(dd_s2[2]);
		sh3 = SUMW'(od_s2[0]) + SUMW'(od_s2[1]) + SUMW'(od_s2[2]);
		sc3 = SUMW'(oo_s2[0]) + SUMW'(oo_s2[1]) + SUMW'(oo_s2[2])
			- $signed(SUMW'({1'b0, rr_s2}));
		qd5  = 65'(hh_s4) - 65'(acc_s4);
		lim5 = 64'({dlim_q, {(FRAC_BITS-2){1'b0}}});
	end

	// ---------------- back stages ----------------
	logic        vld_r1;
	logic [31:0] s_r1;
	logic [$bits(sq1_tag_t)-1:0] tagv_r1;
	sq1_tag_t    tr1;
	assign tr1 = sq1_tag_t'(tagv_r1);

	logic                  vld_s6;
	logic [30:0]           den_s6;
	logic [1:0][30:0]      rem_s6;
	logic [1:0][31:0]      num_s6;
	dv1_tag_t              tag_s6;

	logic signed [33:0]    nr6 [2];
	logic [32:0]           mg6 [2];
	logic [NMW-1:0]        nn6 [2];
	logic [NMW-33:0]       hi6 [2];
	logic [1:0]            ov6;

	always_comb begin
		nr6[0] = -34'(tr1.h) - $signed({2'b00, s_r1});
		nr6[1] = -34'(tr1.h) + $signed({2'b00, s_r1});
		for (int k = 0; k < 2; k++) begin
			mg6[k] = nr6[k][33] ? 33'(-nr6[k]) : 33'(nr6[k]);
			nn6[k] = {mg6[k], {FRAC_BITS{1'b0}}};
			hi6[k] = nn6[k][NMW-1:32];
			// quotient would not fit 32 bits: saturate
			ov6[k] = 32'(hi6[k]) >= $unsigned(tr1.a);
		end
	end

	logic                  vld_d1;
	logic [1:0][31:0]      quo_d1;
	logic [1:0]            rnz_d1;
	logic [$bits(dv1_tag_t)-1:0] tagv_d1;
	dv1_tag_t              td1;
	assign td1 = dv1_tag_t'(tagv_d1);

	logic signed [33:0]    tw7 [2];
	fx_t                   tv7 [2];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			if (td1.ovf[k]) begin
				tw7[k] = td1.neg[k] ? 34'sh200000000 : 34'sh1ffffffff;
			end else if (td1.neg[k]) begin
				// floor of a negative quotient rounds away from zero
				tw7[k] = -($signed({2'b00, quo_d1[k]}) + $signed(34'(rnz_d1[k])));
			end else begin
				tw7[k] = $signed({2'b00, quo_d1[k]});
			end
			tv7[k] = sat32(SAT_W'(tw7[k]));
		end
	end

	logic        vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	fx_t         t1_s7, t2_s7, tmin_s7, tmax_s7;
	logic        hit_s7, qlow_s7;
	fx_t [2:0]   o_s7, d_s7;

	logic signed [63:0] pr_s8 [3];
	logic        occ_s8, hit_s8;
	fx_t         t1_s8;
	fx_t [2:0]   o_s8;

	fx_t [2:0]   p_s9;
	fx_t         t1_s9;
	logic        hit_s9, occ_s9;

	fx_t [2:0]   v_s10, p_s10;
	fx_t         t1_s10;
	logic        hit_s10, occ_s10;

	logic [62:0] sq_s11 [3];
	fx_t [2:0]   v_s11, p_s11;
	fx_t         t1_s11;
	logic        hit_s11, occ_s11;

	logic [63:0] l2_s12;
	sq2_tag_t    tag_s12;

	logic signed [63:0] m_pr [3];
	logic signed [63:0] m_sq [3];
	logic               occ8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_pr[i] = 64'(t1_s7) * 64'(d_s7[i]);
			m_sq[i] = 64'(v_s10[i]) * 64'(v_s10[i]);
		end
		occ8 = hit_s7 && qlow_s7 &&
			((t1_s7 > tmin_s7 && t1_s7 < tmax_s7) ||
			 (t2_s7 > tmin_s7 && t2_s7 < tmax_s7));
	end

	logic        vld_r2;
	logic [31:0] len_r2;
	logic [$bits(sq2_tag_t)-1:0] tagv_r2;
	sq2_tag_t    tr2;
	assign tr2 = sq2_tag_t'(tagv_r2);

	logic                        vld_s13;
	logic [31:0]                 den_s13;
	logic [2:0][31:0]            rem_s13;
	logic [2:0][NORM_BITS:0]     num_s13;
	dv2_tag_t                    tag_s13;
	logic [31:0]                 mag13 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag13[i] = tr2.v[i][31] ? 32'(-tr2.v[i]) : 32'(tr2.v[i]);
		end
	end

	logic                        vld_d2;
	logic [2:0][NORM_BITS:0]     quo_d2;
	logic [2:0]                  rnz_d2;
	logic [$bits(dv2_tag_t)-1:0] tagv_d2;
	dv2_tag_t                    td2;
	assign td2 = dv2_tag_t'(tagv_d2);

	logic [2:0][17:0]  nrm14;
	logic              vld_s14;
	logic [OUT_W-1:0]  out_s14;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (td2.lenz || !td2.hit) begin
				nrm14[i] = '0;
			end else if (td2.neg[i]) begin
				nrm14[i] = 18'(-$signed({1'b0, quo_d2[i]}));
			end else begin
				nrm14[i] = 18'(quo_d2[i]);
			end
		end
	end

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_r1;
			vld_s7  <= vld_d1;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_r2;
			vld_s14 <= vld_d2;
		end
	end

	// ---------------- payload ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: offset from center
			o_s1    <= o_in;
			d_s1    <= d_in;
			tmin_s1 <= s_tdata[223:192];
			tmax_s1 <= s_tdata[255:224];
			for (int i = 0; i < 3; i++) begin
				oc_s1[i] <= sub_sat(o_in[i], ctr[i]);
			end

			// s2: products, floored to Q(F)
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= m_dd[i][63:FRAC_BITS];
				od_s2[i] <= m_od[i][63:FRAC_BITS];
				oo_s2[i] <= m_oo[i][63:FRAC_BITS];
			end
			rr_s2   <= m_rr[63:FRAC_BITS];
			o_s2    <= o_s1;
			d_s2    <= d_s1;
			tmin_s2 <= tmin_s1;
			tmax_s2 <= tmax_s1;

			// s3: quadratic coefficients
			a_s3    <= sat32(SAT_W'(sa3));
			h_s3    <= sat32(SAT_W'(sh3));
			cc_s3   <= sat32(SAT_W'(sc3));
			o_s3    <= o_s2;
			d_s3    <= d_s2;
			tmin_s3 <= tmin_s2;
			tmax_s3 <= tmax_s2;

			// s4: discriminant products
			hh_s4   <= 64'(h_s3) * 64'(h_s3);
			acc_s4  <= 64'(a_s3) * 64'(cc_s3);
			a_s4    <= a_s3;
			h_s4    <= h_s3;
			o_s4    <= o_s3;
			d_s4    <= d_s3;
			tmin_s4 <= tmin_s3;
			tmax_s4 <= tmax_s3;

			// s5: quarter discriminant
			q_s5        <= qd5[64] ? '0 : qd5[63:0];
			tag_s5.hit  <= (a_s4 > 0) && !qd5[64];
			tag_s5.qlow <= qd5[63:0] < lim5;
			tag_s5.h    <= h_s4;
			tag_s5.a    <= a_s4;
			tag_s5.o    <= o_s4;
			tag_s5.d    <= d_s4;
			tag_s5.tmin <= tmin_s4;
			tag_s5.tmax <= tmax_s4;

			// s6: root numerators
			den_s6 <= tr1.a[30:0];
			for (int k = 0; k < 2; k++) begin
				rem_s6[k] <= ov6[k] ? '0 : 31'(hi6[k]);
				num_s6[k] <= nn6[k][31:0];
				tag_s6.neg[k] <= nr6[k][33];
			end
			tag_s6.ovf  <= ov6;
			tag_s6.hit  <= tr1.hit;
			tag_s6.qlow <= tr1.qlow;
			tag_s6.o    <= tr1.o;
			tag_s6.d    <= tr1.d;
			tag_s6.tmin <= tr1.tmin;
			tag_s6.tmax <= tr1.tmax;

			// s7: floored, saturated roots
			t1_s7   <= tv7[0];
			t2_s7   <= tv7[1];
			hit_s7  <= td1.hit;
			qlow_s7 <= td1.qlow;
			o_s7    <= td1.o;
			d_s7    <= td1.d;
			tmin_s7 <= td1.tmin;
			tmax_s7 <= td1.tmax;

			// s8: t * d
			for (int i = 0; i < 3; i++) begin
				pr_s8[i] <= m_pr[i];
			end
			occ_s8 <= occ8;
			hit_s8 <= hit_s7;
			t1_s8  <= t1_s7;
			o_s8   <= o_s7;

			// s9: hit point
			for (int i = 0; i < 3; i++) begin
				p_s9[i] <= sat32(SAT_W'(o_s8[i]) +
					SAT_W'($signed(pr_s8[i][63:FRAC_BITS])));
			end
			t1_s9  <= t1_s8;
			hit_s9 <= hit_s8;
			occ_s9 <= occ_s8;

			// s10: point relative to center
			for (int i = 0; i < 3; i++) begin
				v_s10[i] <= sub_sat(p_s9[i], ctr[i]);
			end
			p_s10   <= p_s9;
			t1_s10  <= t1_s9;
			hit_s10 <= hit_s9;
			occ_s10 <= occ_s9;

			// s11: squares
			for (int i = 0; i < 3; i++) begin
				sq_s11[i] <= m_sq[i][62:0];
			end
			v_s11   <= v_s10;
			p_s11   <= p_s10;
			t1_s11  <= t1_s10;
			hit_s11 <= hit_s10;
			occ_s11 <= occ_s10;

			// s12: squared length
			l2_s12      <= 64'(sq_s11[0]) + 64'(sq_s11[1]) + 64'(sq_s11[2]);
			tag_s12.v   <= v_s11;
			tag_s12.p   <= p_s11;
			tag_s12.t1  <= t1_s11;
			tag_s12.hit <= hit_s11;
			tag_s12.occ <= occ_s11;

			// s13: normal numerators, |v| * 2^NORM_BITS over len
			den_s13 <= len_r2;
			for (int i = 0; i < 3; i++) begin
				rem_s13[i] <= {1'b0, mag13[i][31:1]};
				num_s13[i] <= {mag13[i][0], {NORM_BITS{1'b0}}};
				tag_s13.neg[i] <= tr2.v[i][31];
			end
			tag_s13.lenz <= len_r2 == '0;
			tag_s13.p    <= tr2.p;
			tag_s13.t1   <= tr2.t1;
			tag_s13.hit  <= tr2.hit;
			tag_s13.occ  <= tr2.occ;

			// s14: result word, zeroed on a miss
			out_s14 <= {td2.occ, nrm14[2], nrm14[1], nrm14[0],
				td2.hit ? td2.p : 96'd0,
				td2.hit ? td2.t1 : 32'sd0,
				td2.hit};
		end
	end

	// ---------------- units ----------------
	rsi_isqrt #(
		.IW (64),
		.TW ($bits(sq1_tag_t))
	) u_sqrt_disc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.in_rad   (q_s5),
		.in_tag   (tag_s5),
		.out_vld  (vld_r1),
		.out_root (s_r1),
		.out_tag  (tagv_r1)
	);

	rsi_div #(
		.DW    (31),
		.QW    (32),
		.LANES (2),
		.TW    ($bits(dv1_tag_t))
	) u_div_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.in_den  (den_s6),
		.in_rem  (rem_s6),
		.in_num  (num_s6),
		.in_tag  (tag_s6),
		.out_vld (vld_d1),
		.out_quo (quo_d1),
		.out_rnz (rnz_d1),
		.out_tag (tagv_d1)
	);

	rsi_isqrt #(
		.IW (64),
		.TW ($bits(sq2_tag_t))
	) u_sqrt_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s12),
		.in_rad   (l2_s12),
		.in_tag   (tag_s12),
		.out_vld  (vld_r2),
		.out_root (len_r2),
		.out_tag  (tagv_r2)
	);

	rsi_div #(
		.DW    (32),
		.QW    (NORM_BITS + 1),
		.LANES (3),
		.TW    ($bits(dv2_tag_t))
	) u_div_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s13),
		.in_den  (den_s13),
		.in_rem  (rem_s13),
		.in_num  (num_s13),
		.in_tag  (tag_s13),
		.out_vld (vld_d2),
		.out_quo (quo_d2),
		.out_rnz (rnz_d2),
		.out_tag (tagv_d2)
	);

	rsi_skid #(
		.W (OUT_W)
	) u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s14 && (rnz_d2 == rnz_d2)),
		.in_data  (out_s14),
		.in_rdy   (en),
		.out_vld  (m_tvalid),
		.out_rdy  (m_tready),
		.out_data (m_tdata)
	);

endmodule
